// ===== src/merge_boxes_by_x_overlap_core_assert.svh =====
// Assertion macros for the box merger checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef MERGE_BOXES_BY_X_OVERLAP_CORE_ASSERT_SVH
`define MERGE_BOXES_BY_X_OVERLAP_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define MBX_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define MBX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/mbx_pkg.sv =====
// Shared widths, constants, types and the span union helper of the box merger.
// No dependencies; used by every RTL module of the block.
package mbx_pkg;

  localparam int COORD_W = 12;                  // box column / row
  localparam int EXT_W   = 13;                  // box width / height
  localparam int EDGE_W  = 14;                  // right / bottom edge, x + w - 1
  localparam int RATIO_W = 8;
  localparam int PROD_W  = EXT_W + RATIO_W;     // threshold products

  localparam int IMAGE_DIM = 4096;
  localparam int EXT_MAX   = 8191;
  localparam logic [EDGE_W-1:0] IMG_LIM = EDGE_W'(IMAGE_DIM - 1);

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_RATIO_NUM = 1'b0;        // selected by paddr[2]
  localparam logic REG_RATIO_DEN = 1'b1;
  localparam logic [RATIO_W-1:0] RATIO_NUM_RST = RATIO_W'(1);
  localparam logic [RATIO_W-1:0] RATIO_DEN_RST = RATIO_W'(5);

  // Queues
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [EXT_W-1:0]   w;
    logic [EXT_W-1:0]   h;
  } box_t;

  typedef struct packed {
    box_t              box;
    logic [EDGE_W-1:0] right;
    logic [EDGE_W-1:0] bottom;
  } geom_t;

  typedef struct packed {
    geom_t geom;
    logic  last;
  } cmd_t;

  // Front to back: head of the request queue
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  typedef struct packed {
    box_t box;
    logic final_box;
  } res_t;

  // Back to result queue: up to two results per request, older one first
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } res_push_t;

  typedef struct packed {
    logic [COORD_W-1:0] start;
    logic [EXT_W-1:0]   len;
    logic [EDGE_W-1:0]  stop;
  } span_t;

  // Union of two 1-D spans, far edge clamped to the image, length saturated
  function automatic span_t span_union(input logic [COORD_W-1:0] a0,
                                       input logic [EDGE_W-1:0]  ae,
                                       input logic [COORD_W-1:0] b0,
                                       input logic [EDGE_W-1:0]  be);
    logic [COORD_W-1:0] lo;
    logic [EDGE_W-1:0]  hi;
    logic [EDGE_W-1:0]  len;
    span_t              s;
    lo = (a0 < b0) ? a0 : b0;
    hi = (ae > be) ? ae : be;
    if (hi > IMG_LIM) begin
      hi = IMG_LIM;
    end
    s.start = lo;
    if (hi < EDGE_W'(lo)) begin
      s.len  = EXT_W'(1);
      s.stop = EDGE_W'(lo);
    end else begin
      len = hi - EDGE_W'(lo) + EDGE_W'(1);
      if (len > EDGE_W'(EXT_MAX)) begin
        s.len  = EXT_W'(EXT_MAX);
        s.stop = EDGE_W'(lo) + EDGE_W'(EXT_MAX - 1);
      end else begin
        s.len  = EXT_W'(len);
        s.stop = hi;
      end
    end
    return s;
  endfunction

endpackage

// ===== src/mbx_front.sv =====
// Front end: accepts boxes, normalizes extents, computes far edges and queues requests.
// Depends on mbx_pkg.
module mbx_front import mbx_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [COORD_W-1:0] in_box_x,
  input  logic [COORD_W-1:0] in_box_y,
  input  logic [EXT_W-1:0]   in_box_w,
  input  logic [EXT_W-1:0]   in_box_h,
  input  logic               in_list_end,
  output cmd_head_t          head,
  input  logic               head_pop
);

  cmd_t                mem_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CW-1:0]  cnt_r, cnt_nxt;
  logic                do_push, do_pop;
  logic [EXT_W-1:0]    w_n, h_n;
  cmd_t                cmd_new;

  // Classify: take a zero extent as one, derive right and bottom edges
  always_comb begin
    w_n = (in_box_w == '0) ? EXT_W'(1) : in_box_w;
    h_n = (in_box_h == '0) ? EXT_W'(1) : in_box_h;
    cmd_new.geom.box.x  = in_box_x;
    cmd_new.geom.box.y  = in_box_y;
    cmd_new.geom.box.w  = w_n;
    cmd_new.geom.box.h  = h_n;
    cmd_new.geom.right  = EDGE_W'(in_box_x) + EDGE_W'(w_n) - EDGE_W'(1);
    cmd_new.geom.bottom = EDGE_W'(in_box_y) + EDGE_W'(h_n) - EDGE_W'(1);
    cmd_new.last        = in_list_end;
  end

  assign full    = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = head_pop && (cnt_r != '0);

  // Present the oldest request to the back end
  always_comb begin
    head.valid = (cnt_r != '0);
    head.cmd   = mem_r[rd_ptr_r];
  end

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + CMDQ_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + CMDQ_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CMDQ_CW'(do_push) - CMDQ_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the request
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cmd_new;
    end
  end

endmodule

// ===== src/mbx_back.sv =====
// Back end: compares each request with the held box, merges or emits, flushes on list end.
// Depends on mbx_pkg.
module mbx_back import mbx_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [RATIO_W-1:0] ratio_num,
  input  logic [RATIO_W-1:0] ratio_den,
  input  cmd_head_t          head,
  output logic               head_pop,
  input  logic               res_room,
  output res_push_t          res_push
);

  logic               held_valid_r, held_valid_nxt;
  geom_t              held_r, held_nxt;
  logic               go;
  cmd_t               c;
  logic [COORD_W-1:0] ov_start;
  logic [EDGE_W-1:0]  ov_end;
  logic [EXT_W-1:0]   ov;
  logic [EXT_W-1:0]   narrow;
  logic [PROD_W-1:0]  prod_ov, prod_nw;
  logic               merge;
  span_t              ux, uy;
  geom_t              merged;

  assign go       = head.valid && res_room;
  assign head_pop = go;
  assign c        = head.cmd;

  // Horizontal overlap and narrower width
  always_comb begin
    ov_start = (held_r.box.x > c.geom.box.x) ? held_r.box.x : c.geom.box.x;
    ov_end   = (held_r.right < c.geom.right) ? held_r.right : c.geom.right;
    ov       = (ov_end >= EDGE_W'(ov_start)) ?
               EXT_W'(ov_end - EDGE_W'(ov_start) + EDGE_W'(1)) : '0;
    narrow   = (held_r.box.w < c.geom.box.w) ? held_r.box.w : c.geom.box.w;
  end

  // Exact ratio test: overlap * den > num * narrow
  assign prod_ov = PROD_W'(ov) * PROD_W'(ratio_den);
  assign prod_nw = PROD_W'(ratio_num) * PROD_W'(narrow);
  assign merge   = held_valid_r && (prod_ov > prod_nw);

  // Union in both axes
  always_comb begin
    ux = span_union(held_r.box.x, held_r.right, c.geom.box.x, c.geom.right);
    uy = span_union(held_r.box.y, held_r.bottom, c.geom.box.y, c.geom.bottom);
    merged.box.x  = ux.start;
    merged.box.w  = ux.len;
    merged.right  = ux.stop;
    merged.box.y  = uy.start;
    merged.box.h  = uy.len;
    merged.bottom = uy.stop;
  end

  // Pick the next held box and the results of this request
  always_comb begin
    held_nxt       = merge ? merged : c.geom;
    held_valid_nxt = !c.last;
    res_push.v0           = go && held_valid_r && !merge;
    res_push.r0.box       = held_r.box;
    res_push.r0.final_box = 1'b0;
    res_push.v1           = go && c.last;
    res_push.r1.box       = held_nxt.box;
    res_push.r1.final_box = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
    end else if (go) begin
      held_valid_r <= held_valid_nxt;
    end
  end

  // Hold the current box
  always_ff @(posedge clk) begin
    if (go) begin
      held_r <= held_nxt;
    end
  end

endmodule

// ===== src/mbx_outq.sv =====
// Result queue: takes up to two results a cycle from the back end, hands out one.
// Depends on mbx_pkg.
module mbx_outq import mbx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  res_push_t res_push,
  output logic      res_room,
  output logic      empty,
  input  logic      pop,
  output res_t      head
);

  res_t               mem_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OUTQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OUTQ_CW-1:0] cnt_r, cnt_nxt;
  logic [OUTQ_CW-1:0] n_push;
  logic               do_pop;
  logic               any_push;
  res_t               first;

  // Room for a full request's worth of results
  assign res_room = (cnt_r <= OUTQ_CW'(OUTQ_DEPTH - 2));
  assign empty    = (cnt_r == '0);
  assign do_pop   = pop && !empty;
  assign head     = mem_r[rd_ptr_r];

  // Pack the older valid result first
  always_comb begin
    any_push   = res_push.v0 || res_push.v1;
    first      = res_push.v0 ? res_push.r0 : res_push.r1;
    n_push     = OUTQ_CW'(res_push.v0) + OUTQ_CW'(res_push.v1);
    wr_ptr_nxt = wr_ptr_r + OUTQ_AW'(n_push);
    rd_ptr_nxt = do_pop ? rd_ptr_r + OUTQ_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + n_push - OUTQ_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store results
  always_ff @(posedge clk) begin
    if (any_push) begin
      mem_r[wr_ptr_r] <= first;
    end
    if (res_push.v0 && res_push.v1) begin
      mem_r[wr_ptr_r + OUTQ_AW'(1)] <= res_push.r1;
    end
  end

endmodule

// ===== src/merge_boxes_by_x_overlap_core.sv =====
// Top level of the box merger: configuration registers, front end, back end, result queue.
// Depends on mbx_pkg, mbx_front, mbx_back and mbx_outq.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------------
//   input    | push / full        | in_box_x, in_box_y, in_box_w, in_box_h, in_list_end
//   result   | empty / pop        | out_x, out_y, out_w, out_h, out_final
//   config   | psel/penable/pready| paddr, pwdata, pwrite, prdata
//
// One box per cycle sustained while the result queue has room; an accepted box is
// registered in the request queue, and its results in the result queue, before a pop.
// The held-box compare, multiply and union are combinational in the back end.
// Synchronous reset empties both queues, invalidates the held box, sets the ratio to 1/5.
// full rises with four requests waiting; the back end waits until the result
// queue has two free entries.
module merge_boxes_by_x_overlap_core import mbx_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [COORD_W-1:0] in_box_x,
  input  logic [COORD_W-1:0] in_box_y,
  input  logic [EXT_W-1:0]   in_box_w,
  input  logic [EXT_W-1:0]   in_box_h,
  input  logic               in_list_end,
  output logic               empty,
  input  logic               pop,
  output logic [COORD_W-1:0] out_x,
  output logic [COORD_W-1:0] out_y,
  output logic [EXT_W-1:0]   out_w,
  output logic [EXT_W-1:0]   out_h,
  output logic               out_final,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [RATIO_W-1:0] ratio_num_r;
  logic [RATIO_W-1:0] ratio_den_r;
  logic               cfg_wr;
  cmd_head_t          cmd_head;
  logic               cmd_pop;
  logic               res_room;
  res_push_t          res_push;
  res_t               res_head;

  // Register writes complete in the access cycle
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_num_r <= RATIO_NUM_RST;
      ratio_den_r <= RATIO_DEN_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_RATIO_NUM: ratio_num_r <= pwdata[RATIO_W-1:0];
        REG_RATIO_DEN: ratio_den_r <= pwdata[RATIO_W-1:0];
        default:       ratio_num_r <= ratio_num_r;
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    unique case (paddr[2])
      REG_RATIO_NUM: prdata = DATA_W'(ratio_num_r);
      REG_RATIO_DEN: prdata = DATA_W'(ratio_den_r);
      default:       prdata = '0;
    endcase
  end

  mbx_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_box_x    (in_box_x),
    .in_box_y    (in_box_y),
    .in_box_w    (in_box_w),
    .in_box_h    (in_box_h),
    .in_list_end (in_list_end),
    .head        (cmd_head),
    .head_pop    (cmd_pop)
  );

  mbx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ratio_num (ratio_num_r),
    .ratio_den (ratio_den_r),
    .head      (cmd_head),
    .head_pop  (cmd_pop),
    .res_room  (res_room),
    .res_push  (res_push)
  );

  mbx_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_room (res_room),
    .empty    (empty),
    .pop      (pop),
    .head     (res_head)
  );

  assign out_x     = res_head.box.x;
  assign out_y     = res_head.box.y;
  assign out_w     = res_head.box.w;
  assign out_h     = res_head.box.h;
  assign out_final = res_head.final_box;

endmodule

// ===== src/mbx_checker.sv =====
// Port-level checker for the box merger, bound to the top level.
// Depends on merge_boxes_by_x_overlap_core_assert.svh.
`include "merge_boxes_by_x_overlap_core_assert.svh"

module mbx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [11:0] out_x,
  input logic [11:0] out_y,
  input logic [12:0] out_w,
  input logic [12:0] out_h,
  input logic        out_final
);

  // Every emitted box has a nonzero extent
  `MBX_ASSERT_IMPL(a_ext_nonzero, !empty, out_w != '0 && out_h != '0, "zero extent emitted")

  // With the result queue drained, the back end must free a request slot
  `MBX_ASSERT_NEXT(a_drain, full && empty, !full, "request queue stuck while results empty")

  // A waiting result stays until popped
  `MBX_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty, "result dropped without pop")

  // A waiting result does not change
  `MBX_ASSERT_NEXT(a_res_stable, !empty && !pop,
    $stable(out_x) && $stable(out_y) && $stable(out_w) && $stable(out_h) && $stable(out_final),
    "result changed while waiting")

endmodule

bind merge_boxes_by_x_overlap_core mbx_checker u_mbx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_w     (out_w),
  .out_h     (out_h),
  .out_final (out_final)
);
